// ===== rtl/lfg_pkg.sv =====
package lfg_pkg;

   // fixed widths of the transaction and register fields
   localparam int FIELD_W     = 32;
   localparam int LAG_FIELD_W = 7;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 2;

   // defaults for the top level parameters
   localparam int DEF_MAX_LAG     = 64;
   localparam int DEF_VALUE_WIDTH = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LAG_A     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAG_B     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_SELECT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS   = 2'd3;

   // register reset values
   localparam logic [LAG_FIELD_W-1:0] LAG_A_RESET     = 7'd1;
   localparam logic [LAG_FIELD_W-1:0] LAG_B_RESET     = 7'd2;
   localparam logic [FIELD_W-1:0]     MODULUS_RESET   = 32'hFFFF_FFFF;

   // combining operations
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_XOR = 2'd3;

   // transaction kinds
   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_GENERATE = 1'b1;

   // modes of the serial modular unit
   typedef enum logic [1:0] {
      MOD_DIV,
      MOD_MUL,
      MOD_ADD,
      MOD_SUB
   } mod_op_type;

   typedef struct packed {
      logic       start;
      mod_op_type op;
   } mod_cmd_type;

   typedef struct packed {
      logic rd_en;
      logic push;
      logic count_seed;
   } ring_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_B,
      ST_SPLIT,
      ST_RED_A,
      ST_RED_B,
      ST_FINAL,
      ST_DELIVER
   } lfg_state_type;

endpackage

// ===== rtl/lfg_ring.sv =====
module lfg_ring #(
   parameter int MAX_LAG     = 64,
   parameter int VALUE_WIDTH = 32,
   localparam int LAG_W      = $clog2(MAX_LAG + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lfg_pkg::ring_ctl_type     ctl,
   input  logic [LAG_W-1:0]          rd_lag,
   input  logic [VALUE_WIDTH-1:0]    wr_data,
   output logic [VALUE_WIDTH-1:0]    rd_data,
   output logic [LAG_W-1:0]          seeds_loaded
);
   import lfg_pkg::*;

   localparam int IDX_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
   localparam logic [LAG_W:0]   DEPTH_EXT = (LAG_W + 1)'(MAX_LAG);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_LAG - 1);
   localparam logic [LAG_W-1:0] SEED_MAX  = LAG_W'(MAX_LAG);

   logic [VALUE_WIDTH-1:0] mem [MAX_LAG];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]       wr_idx_ff;
   logic [IDX_W-1:0]       wr_idx_in;
   logic [LAG_W-1:0]       seeds_ff;
   logic [LAG_W-1:0]       seeds_in;
   logic [LAG_W:0]         wi_ext;
   logic [LAG_W:0]         lag_ext;
   logic [LAG_W:0]         pos_full;
   logic [IDX_W-1:0]       rd_pos;

   // slot lag places behind the write pointer, wrapping around the ring
   always_comb begin
      wi_ext  = (LAG_W + 1)'(wr_idx_ff);
      lag_ext = (LAG_W + 1)'(rd_lag);
      if (wi_ext >= lag_ext) begin
         pos_full = wi_ext - lag_ext;
      end else begin
         pos_full = wi_ext + DEPTH_EXT - lag_ext;
      end
      rd_pos = pos_full[IDX_W-1:0];
   end

   always_comb begin
      wr_idx_in = wr_idx_ff;
      seeds_in  = seeds_ff;
      if (ctl.push) begin
         wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         if (ctl.count_seed && (seeds_ff != SEED_MAX)) begin
            seeds_in = seeds_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         seeds_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         seeds_ff  <= seeds_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_idx_ff] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_pos];
      end
   end

   assign rd_data      = rd_data_ff;
   assign seeds_loaded = seeds_ff;

endmodule

// ===== rtl/lfg_mod_unit.sv =====
module lfg_mod_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lfg_pkg::mod_cmd_type   cmd,
   input  logic [VALUE_WIDTH-1:0] x_in,
   input  logic [VALUE_WIDTH-1:0] y_in,
   input  logic [VALUE_WIDTH-1:0] m_in,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result
);
   import lfg_pkg::*;

   localparam int W     = VALUE_WIDTH;
   localparam int CNT_W = $clog2(W + 1);
   localparam logic [CNT_W-1:0] BIT_COUNT = CNT_W'(W);
   localparam logic [CNT_W-1:0] ONE_STEP  = CNT_W'(1);

   logic             busy_ff;
   logic             done_ff;
   logic             phase_ff;
   mod_op_type       op_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     acc_ff;
   logic [W-1:0]     dsr_ff;
   logic [W-1:0]     mcand_ff;

   logic         m_nz;
   logic [W-1:0] a_sel;
   logic [W-1:0] b_sel;
   logic         cin;
   logic [W:0]   sum;
   logic [W:0]   red;
   logic [W:0]   diff;
   logic [W:0]   diff_fix;
   logic [W-1:0] acc_in;
   logic         shift_now;
   logic         last;

   // one add, one compare and subtract per cycle
   always_comb begin
      m_nz  = |m_in;
      a_sel = acc_ff;
      b_sel = acc_ff;
      cin   = 1'b0;
      case (op_ff)
         MOD_DIV: cin = dsr_ff[W-1];
         MOD_MUL: begin
            if (phase_ff) begin
               b_sel = dsr_ff[W-1] ? mcand_ff : '0;
            end
         end
         MOD_ADD: b_sel = mcand_ff;
         default: b_sel = acc_ff;
      endcase
      sum = {1'b0, a_sel} + {1'b0, b_sel} + (W + 1)'(cin);
      if (m_nz && (sum >= {1'b0, m_in})) begin
         red = sum - {1'b0, m_in};
      end else begin
         red = sum;
      end

      // borrow means add the modulus back
      diff = {1'b0, acc_ff} - {1'b0, mcand_ff};
      if (m_nz && diff[W]) begin
         diff_fix = diff + {1'b0, m_in};
      end else begin
         diff_fix = diff;
      end

      acc_in    = (op_ff == MOD_SUB) ? diff_fix[W-1:0] : red[W-1:0];
      shift_now = (op_ff != MOD_MUL) || phase_ff;
      last      = (cnt_ff == ONE_STEP) && shift_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
         end else if (busy_ff) begin
            if (op_ff == MOD_MUL) begin
               phase_ff <= ~phase_ff;
            end
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= cmd.op;
         acc_ff   <= ((cmd.op == MOD_ADD) || (cmd.op == MOD_SUB)) ? x_in : '0;
         dsr_ff   <= (cmd.op == MOD_DIV) ? x_in : y_in;
         mcand_ff <= (cmd.op == MOD_MUL) ? x_in : y_in;
         cnt_ff   <= ((cmd.op == MOD_ADD) || (cmd.op == MOD_SUB)) ? ONE_STEP : BIT_COUNT;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         if (shift_now) begin
            dsr_ff <= {dsr_ff[W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ===== rtl/lagged_fibonacci_generator_unit.sv =====
// lagged fibonacci generator, one transaction at a time, W = VALUE_WIDTH
// load reduces the seed and appends it; generate reads both lags, reduces each, combines
// and appends (xor: combine, reduce once); too few seeds answers zero with short history
// throughput: a new request is taken the cycle after the result is registered,
// even while that result still waits on the rsp side
// synchronous reset clears control, lags 1 and 2, add, all-ones modulus; ring not cleared
module lagged_fibonacci_generator_unit #(
   parameter int MAX_LAG     = lfg_pkg::DEF_MAX_LAG,
   parameter int VALUE_WIDTH = lfg_pkg::DEF_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [lfg_pkg::FIELD_W-1:0]       req_seed_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lfg_pkg::FIELD_W-1:0]       rsp_value,
   output logic                              rsp_short_history,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lfg_pkg::FIELD_W-1:0]       csr_data
);
   import lfg_pkg::*;

   localparam int W     = VALUE_WIDTH;
   localparam int LAG_W = $clog2(MAX_LAG + 1);
   localparam int CMP_W = (LAG_W > LAG_FIELD_W) ? LAG_W : LAG_FIELD_W;

   // configuration registers
   logic [LAG_FIELD_W-1:0] lag_a_ff;
   logic [LAG_FIELD_W-1:0] lag_b_ff;
   logic [OP_W-1:0]        op_select_ff;
   logic [FIELD_W-1:0]     modulus_ff;

   // sequencer state and operand holding registers
   lfg_state_type state_ff, state_in;
   logic          kind_ff, kind_in;
   logic [W-1:0]  pa_ff, pa_in;
   logic [W-1:0]  pb_ff, pb_in;
   logic [W-1:0]  ra_ff, ra_in;
   logic [W-1:0]  res_value_ff, res_value_in;
   logic          res_short_ff, res_short_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_short_ff, rsp_short_in;

   // between the sequencer, the ring and the modular unit
   ring_ctl_type  ring_ctl;
   logic [LAG_W-1:0] rd_lag;
   logic [W-1:0]     rd_data;
   logic [LAG_W-1:0] seeds_loaded;
   mod_cmd_type      mod_cmd;
   logic [W-1:0]     mod_x;
   logic [W-1:0]     mod_y;
   logic [W-1:0]     mod_m;
   logic             mod_done;
   logic [W-1:0]     mod_result;

   logic [LAG_W-1:0] la;
   logic [LAG_W-1:0] lb;
   logic [LAG_W-1:0] need;
   logic             short_hist;
   mod_op_type       comb_op;

   // zero lag means one, a lag beyond the ring saturates at its depth
   function automatic logic [LAG_W-1:0] clamp_lag(input logic [LAG_FIELD_W-1:0] lag);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(lag);
      if (ext == '0) begin
         clamp_lag = LAG_W'(1);
      end else if (ext > CMP_W'(MAX_LAG)) begin
         clamp_lag = LAG_W'(MAX_LAG);
      end else begin
         clamp_lag = LAG_W'(ext);
      end
   endfunction

   // register writes are taken whenever out of reset
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_a_ff     <= LAG_A_RESET;
         lag_b_ff     <= LAG_B_RESET;
         op_select_ff <= OP_ADD;
         modulus_ff   <= MODULUS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LAG_A:     lag_a_ff     <= csr_data[LAG_FIELD_W-1:0];
            CSR_LAG_B:     lag_b_ff     <= csr_data[LAG_FIELD_W-1:0];
            CSR_OP_SELECT: op_select_ff <= csr_data[OP_W-1:0];
            CSR_MODULUS:   modulus_ff   <= csr_data;
         endcase
      end
   end

   // modulus at the internal width; zero means plain wrap-around
   assign mod_m      = W'(modulus_ff);
   assign la         = clamp_lag(lag_a_ff);
   assign lb         = clamp_lag(lag_b_ff);
   assign need       = (la > lb) ? la : lb;
   assign short_hist = seeds_loaded < need;

   always_comb begin
      unique case (op_select_ff)
         OP_ADD:  comb_op = MOD_ADD;
         OP_SUB:  comb_op = MOD_SUB;
         default: comb_op = MOD_MUL;
      endcase
   end

   // history ring of the last MAX_LAG values
   lfg_ring #(
      .MAX_LAG     (MAX_LAG),
      .VALUE_WIDTH (W)
   ) u_ring (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ring_ctl),
      .rd_lag       (rd_lag),
      .wr_data      (mod_result),
      .rd_data      (rd_data),
      .seeds_loaded (seeds_loaded)
   );

   // bit-serial modular reduce / multiply plus modular add and subtract
   lfg_mod_unit #(
      .VALUE_WIDTH (W)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mod_cmd),
      .x_in   (mod_x),
      .y_in   (mod_y),
      .m_in   (mod_m),
      .done   (mod_done),
      .result (mod_result)
   );

   // sequencer: read both lags, reduce the operands, combine, append, deliver (xor: combine, reduce once)
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      ra_in         = ra_ff;
      res_value_in  = res_value_ff;
      res_short_in  = res_short_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_short_in  = rsp_short_ff;
      ring_ctl      = '0;
      rd_lag        = la;
      mod_cmd.start = 1'b0;
      mod_cmd.op    = MOD_DIV;
      mod_x         = pa_ff;
      mod_y         = mod_result;
      req_ready     = (state_ff == ST_IDLE) && !reset;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               if (req_kind == KIND_LOAD) begin
                  // seed goes straight into the reduction
                  mod_cmd.start = 1'b1;
                  mod_x         = W'(req_seed_value);
                  state_in      = ST_FINAL;
               end else if (short_hist) begin
                  res_value_in = '0;
                  res_short_in = 1'b1;
                  state_in     = ST_DELIVER;
               end else begin
                  ring_ctl.rd_en = 1'b1;
                  rd_lag         = la;
                  state_in       = ST_READ_B;
               end
            end
         end
         ST_READ_B: begin
            ring_ctl.rd_en = 1'b1;
            rd_lag         = lb;
            pa_in          = rd_data;
            state_in       = ST_SPLIT;
         end
         ST_SPLIT: begin
            mod_cmd.start = 1'b1;
            if (op_select_ff == OP_XOR) begin
               // xor the raw values, reduce once
               mod_x    = pa_ff ^ rd_data;
               state_in = ST_FINAL;
            end else begin
               pb_in    = rd_data;
               mod_x    = pa_ff;
               state_in = ST_RED_A;
            end
         end
         ST_RED_A: begin
            if (mod_done) begin
               ra_in         = mod_result;
               mod_cmd.start = 1'b1;
               mod_x         = pb_ff;
               state_in      = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (mod_done) begin
               mod_cmd.start = 1'b1;
               mod_cmd.op    = comb_op;
               mod_x         = ra_ff;
               mod_y         = mod_result;
               state_in      = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (mod_done) begin
               ring_ctl.push       = 1'b1;
               ring_ctl.count_seed = (kind_ff == KIND_LOAD);
               res_value_in        = mod_result;
               res_short_in        = 1'b0;
               state_in            = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = FIELD_W'(res_value_ff);
               rsp_short_in = res_short_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      ra_ff        <= ra_in;
      res_value_ff <= res_value_in;
      res_short_ff <= res_short_in;
      rsp_value_ff <= rsp_value_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_short_history = rsp_short_ff;

endmodule
